### src/fixed_point_alu_defines.svh
// Assertion macros used by the checker file.
`ifndef FIXED_POINT_ALU_DEFINES_SVH
`define FIXED_POINT_ALU_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FXA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fixed_point_alu check failed");

// Next-cycle implication, disabled during reset.
`define FXA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fixed_point_alu check failed");

`endif

### src/fxa_pkg.sv
// ----------------------------------------------------------------------------
// fxa_pkg
// Types and constants of the fixed-point ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fxa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int NCELL     = 32;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_DIV   = 4'd3,
        OP_GT    = 4'd4,
        OP_LT    = 4'd5,
        OP_GE    = 4'd6,
        OP_LE    = 4'd7,
        OP_EQ    = 4'd8,
        OP_NE    = 4'd9,
        OP_MIN   = 4'd10,
        OP_MAX   = 4'd11,
        OP_INC   = 4'd12,
        OP_DEC   = 4'd13,
        OP_TOINT = 4'd14
    } t_op;

    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_req;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic               overflowed;
        logic               divided_by_zero;
    } t_rsp;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] res;
        logic        cmp;
        logic        ovf;
        logic        dz;
        logic        neg_m;
        logic        neg_d;
        logic [63:0] mag_m;
        logic        div_ovf;
        logic [32:0] rem;
        logic [31:0] qn;
        logic [32:0] den;
    } t_cell;

endpackage

`default_nettype wire

### src/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed Q-format ALU: add, sub, mul, div, compares, min, max, inc, dec, toint.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_req with i_req_valid / o_req_ready; results leave on
//   o_rsp with o_rsp_valid / i_rsp_ready. One result per request, in order.
//   Path from acceptance to o_rsp_valid: three prepare stages (multiply,
//   magnitudes, rounding offset), 32 division cells, one saturation stage.
//   Every operation takes the same path.
//   Throughput is one request per cycle while o_rsp is not stalled; the
//   division chain, one quotient bit per cell, sets the latency.
//   Each stage holds while its successor is full and stalled, so bubbles
//   close up and requests keep entering while a result waits.
//   Reset clears all stage valid bits; no result is pending afterwards.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_alu (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_req_valid,
    output logic              o_req_ready,
    input  wire fxa_pkg::t_req i_req,
    output logic              o_rsp_valid,
    input  wire logic         i_rsp_ready,
    output fxa_pkg::t_rsp     o_rsp
);
    import fxa_pkg::*;

    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

    function automatic logic [32:0] sat33(input logic [32:0] s);
        logic [32:0] o;
        if (s[32] != s[31]) begin
            o = {1'b1, s[32] ? MIN32 : MAX32};
        end else begin
            o = {1'b0, s[31:0]};
        end
        return o;
    endfunction

    function automatic logic [32:0] sat_mag(input logic [63:0] m, input logic big,
                                            input logic neg);
        logic [32:0] o;
        if (neg) begin
            if (big || m > 64'h8000_0000) begin
                o = {1'b1, MIN32};
            end else begin
                o = {1'b0, 32'(-m)};
            end
        end else begin
            if (big || m > 64'h7FFF_FFFF) begin
                o = {1'b1, MAX32};
            end else begin
                o = {1'b0, m[31:0]};
            end
        end
        return o;
    endfunction

    // Stage 1
    logic               r_v1;
    logic [3:0]         r_op1;
    logic [31:0]        r_res1;
    logic               r_cmp1, r_ovf1, r_dz1, r_negd1;
    logic signed [63:0] r_prod1;
    logic [63:0]        r_num1;
    logic [31:0]        r_den1;

    // Stage 2
    logic               r_v2;
    logic [3:0]         r_op2;
    logic [31:0]        r_res2;
    logic               r_cmp2, r_ovf2, r_dz2, r_negd2, r_negm2;
    logic [63:0]        r_mp2;
    logic [63:0]        r_nn2;
    logic [32:0]        r_dd2;

    // Stage 3
    logic               r_v3;
    t_cell              r_c3;
    t_cell              n_c3;

    // Output
    logic               r_ov;
    t_rsp               r_rsp;
    t_rsp               n_rsp;

    logic               load_out, load3, load2, load1;
    logic [NCELL:0]     cell_load;
    logic [NCELL:0]     cell_valid;
    t_cell              cell_data [NCELL+1];

    logic signed [31:0] a, b;
    logic [32:0]        sum, dif, incv, decv;
    logic [31:0]        mag_a, mag_b;
    logic [31:0]        n_res1;
    logic               n_cmp1, n_ovf1, n_dz1;
    logic signed [63:0] n_prod1;
    logic [32:0]        sm;

    assign load_out = !r_ov || i_rsp_ready;
    assign cell_load[NCELL] = load_out;
    assign load3 = !r_v3 || cell_load[0];
    assign load2 = !r_v2 || load3;
    assign load1 = !r_v1 || load2;
    assign o_req_ready = load1;
    assign o_rsp_valid = r_ov;
    assign o_rsp = r_rsp;

    always_comb begin
        a = i_req.operand_a;
        b = i_req.operand_b;
        sum  = {a[31], a} + {b[31], b};
        dif  = {a[31], a} - {b[31], b};
        incv = {a[31], a} + 33'd1;
        decv = {a[31], a} - 33'd1;
        mag_a = a[31] ? 32'(-a) : a;
        mag_b = b[31] ? 32'(-b) : b;
        n_prod1 = a * b;
        n_res1 = '0;
        n_cmp1 = 1'b0;
        n_ovf1 = 1'b0;
        n_dz1  = 1'b0;
        case (i_req.opcode)
            OP_ADD: begin
                {n_ovf1, n_res1} = sat33(sum);
            end
            OP_SUB: begin
                {n_ovf1, n_res1} = sat33(dif);
            end
            OP_DIV: begin
                n_dz1 = (b == 32'sd0);
            end
            OP_GT:  n_cmp1 = a > b;
            OP_LT:  n_cmp1 = a < b;
            OP_GE:  n_cmp1 = a >= b;
            OP_LE:  n_cmp1 = a <= b;
            OP_EQ:  n_cmp1 = a == b;
            OP_NE:  n_cmp1 = a != b;
            OP_MIN: n_res1 = (a < b) ? a : b;
            OP_MAX: n_res1 = (a > b) ? a : b;
            OP_INC: begin
                {n_ovf1, n_res1} = sat33(incv);
            end
            OP_DEC: begin
                {n_ovf1, n_res1} = sat33(decv);
            end
            OP_TOINT: n_res1 = a >>> FRAC_BITS;
            default: begin
                n_res1 = '0;
            end
        endcase
    end

    always_comb begin
        n_c3 = '0;
        n_c3.op      = r_op2;
        n_c3.res     = r_res2;
        n_c3.cmp     = r_cmp2;
        n_c3.ovf     = r_ovf2;
        n_c3.dz      = r_dz2;
        n_c3.neg_m   = r_negm2;
        n_c3.neg_d   = r_negd2;
        n_c3.mag_m   = (r_mp2 + HALF) >> FRAC_BITS;
        n_c3.div_ovf = {1'b0, r_nn2[63:32]} >= r_dd2;
        n_c3.rem     = {1'b0, r_nn2[63:32]};
        n_c3.qn      = r_nn2[31:0];
        n_c3.den     = r_dd2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (load1) r_v1 <= i_req_valid;
            if (load2) r_v2 <= r_v1;
            if (load3) r_v3 <= r_v2;
            if (load_out) r_ov <= cell_valid[NCELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_op1   <= i_req.opcode;
            r_res1  <= n_res1;
            r_cmp1  <= n_cmp1;
            r_ovf1  <= n_ovf1;
            r_dz1   <= n_dz1;
            r_negd1 <= i_req.operand_a[31] != i_req.operand_b[31];
            r_prod1 <= n_prod1;
            r_num1  <= 64'(mag_a) << FRAC_BITS;
            r_den1  <= mag_b;
        end
        if (load2) begin
            r_op2   <= r_op1;
            r_res2  <= r_res1;
            r_cmp2  <= r_cmp1;
            r_ovf2  <= r_ovf1;
            r_dz2   <= r_dz1;
            r_negd2 <= r_negd1;
            r_negm2 <= r_prod1[63];
            r_mp2   <= r_prod1[63] ? 64'(-r_prod1) : 64'(r_prod1);
            r_nn2   <= {r_num1[62:0], 1'b0} + 64'(r_den1);
            r_dd2   <= {r_den1, 1'b0};
        end
        if (load3) begin
            r_c3 <= n_c3;
        end
        if (load_out) begin
            r_rsp <= n_rsp;
        end
    end

    assign cell_valid[0] = r_v3;
    assign cell_data[0]  = r_c3;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        fxa_div_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load_next (cell_load[k+1]),
            .i_valid     (cell_valid[k]),
            .i_data      (cell_data[k]),
            .o_load      (cell_load[k]),
            .o_valid     (cell_valid[k+1]),
            .o_data      (cell_data[k+1])
        );
    end

    always_comb begin
        n_rsp = '0;
        n_rsp.result_value    = cell_data[NCELL].res;
        n_rsp.compare_true    = cell_data[NCELL].cmp;
        n_rsp.overflowed      = cell_data[NCELL].ovf;
        n_rsp.divided_by_zero = cell_data[NCELL].dz;
        sm = '0;
        case (cell_data[NCELL].op)
            OP_MUL: begin
                sm = sat_mag(cell_data[NCELL].mag_m, 1'b0, cell_data[NCELL].neg_m);
                n_rsp.overflowed   = sm[32];
                n_rsp.result_value = sm[31:0];
            end
            OP_DIV: begin
                sm = sat_mag(64'(cell_data[NCELL].qn), cell_data[NCELL].div_ovf,
                             cell_data[NCELL].neg_d);
                if (!cell_data[NCELL].dz) begin
                    n_rsp.overflowed   = sm[32];
                    n_rsp.result_value = sm[31:0];
                end
            end
            default: begin
                sm = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/fxa_div_cell.sv
// ----------------------------------------------------------------------------
// fxa_div_cell
// One restoring-division step with its pipeline slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fxa_div_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load_next,
    input  wire logic          i_valid,
    input  wire fxa_pkg::t_cell i_data,
    output logic               o_load,
    output logic               o_valid,
    output fxa_pkg::t_cell     o_data
);
    import fxa_pkg::*;

    logic  r_valid;
    t_cell r_data;
    t_cell n_data;
    logic [33:0] rem2;
    logic [33:0] diff;
    logic        take;

    assign o_load  = !r_valid || i_load_next;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        rem2 = {i_data.rem, i_data.qn[31]};
        diff = rem2 - {1'b0, i_data.den};
        take = rem2 >= {1'b0, i_data.den};
        n_data     = i_data;
        n_data.rem = take ? diff[32:0] : rem2[32:0];
        n_data.qn  = {i_data.qn[30:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

### src/fxa_checker.sv
// ----------------------------------------------------------------------------
// fxa_checker
// Port-level checks of the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_alu_defines.svh"

module fxa_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rsp_ready,
    input  wire logic          i_rsp_valid,
    input  wire fxa_pkg::t_rsp i_rsp
);
    import fxa_pkg::*;

    `FXA_ASSERT_NEXT(a_hold, i_rsp_valid && !i_rsp_ready,
                     i_rsp_valid && $stable(i_rsp))
    `FXA_ASSERT_NOW(a_cmp_clean, i_rsp_valid && i_rsp.compare_true,
                    i_rsp.result_value == 0 && !i_rsp.overflowed && !i_rsp.divided_by_zero)
    `FXA_ASSERT_NOW(a_dz_zero, i_rsp_valid && i_rsp.divided_by_zero,
                    i_rsp.result_value == 0 && !i_rsp.overflowed)
    `FXA_ASSERT_NOW(a_sat_bound, i_rsp_valid && i_rsp.overflowed,
                    i_rsp.result_value == MAX32 || i_rsp.result_value == MIN32)

endmodule

bind fixed_point_alu fxa_checker u_fxa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_ready (i_rsp_ready),
    .i_rsp_valid (o_rsp_valid),
    .i_rsp       (o_rsp)
);

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fixed_point_alu: a directed table of requests,
// then random requests with random idling on both sides, each result
// checked in order against a table value or an in-bench arithmetic predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import fxa_pkg::*;

    localparam int RUN_LIMIT = 400000;
    localparam int TAIL      = 60;

    typedef struct {
        logic [3:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        bit          has_exp;
        t_rsp        exp;
    } t_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_req_valid = 1'b0;
    logic  o_req_ready;
    t_req  i_req = '0;
    logic  o_rsp_valid;
    logic  i_rsp_ready = 1'b0;
    t_rsp  o_rsp;

    t_rsp  expected_rsp[$];
    int    mismatches = 0;
    int    cycles = 0;
    int    send_idle = 8;
    int    recv_idle = 64;
    int    hold_cycles = 0;

    fixed_point_alu dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] sat32(input logic signed [65:0] v, ref logic ovf);
        if (v > 66'sd2147483647) begin
            ovf = 1'b1;
            return MAX32;
        end
        if (v < -66'sd2147483648) begin
            ovf = 1'b1;
            return MIN32;
        end
        return v[31:0];
    endfunction

    function automatic t_rsp alu_result(input logic [3:0] op, input logic [31:0] ua,
                                        input logic [31:0] ub);
        t_rsp r;
        logic signed [65:0] a, b, p, q;
        logic [65:0] mag, num, den;
        logic ovf;
        a = $signed(ua);
        b = $signed(ub);
        r = '0;
        ovf = 1'b0;
        case (op)
            OP_ADD: r.result_value = sat32(a + b, ovf);
            OP_SUB: r.result_value = sat32(a - b, ovf);
            OP_MUL: begin
                p = a * b;
                mag = p < 0 ? -p : p;
                q = (mag + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                r.result_value = sat32(p < 0 ? -q : q, ovf);
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.divided_by_zero = 1'b1;
                end else begin
                    num = (a < 0 ? -a : a) << FRAC_BITS;
                    den = b < 0 ? -b : b;
                    q = (2 * num + den) / (2 * den);
                    r.result_value = sat32(((a < 0) != (b < 0)) ? -q : q, ovf);
                end
            end
            OP_GT: r.compare_true = a > b;
            OP_LT: r.compare_true = a < b;
            OP_GE: r.compare_true = a >= b;
            OP_LE: r.compare_true = a <= b;
            OP_EQ: r.compare_true = a == b;
            OP_NE: r.compare_true = a != b;
            OP_MIN: r.result_value = a < b ? ua : ub;
            OP_MAX: r.result_value = a > b ? ua : ub;
            OP_INC: r.result_value = sat32(a + 1, ovf);
            OP_DEC: r.result_value = sat32(a - 1, ovf);
            OP_TOINT: r.result_value = $signed(ua) >>> FRAC_BITS;
            default: ;
        endcase
        r.overflowed = ovf;
        return r;
    endfunction

    function automatic t_row row(input logic [3:0] op, input logic [31:0] a,
                                 input logic [31:0] b, input bit has_exp,
                                 input logic [31:0] v, input logic c,
                                 input logic o, input logic z);
        t_row x;
        x.op = op;
        x.a = a;
        x.b = b;
        x.has_exp = has_exp;
        x.exp = '{v, c, o, z};
        return x;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return MAX32 - $urandom_range(0, 2);
            1: return MIN32 + $urandom_range(0, 2);
            2: return $urandom_range(0, 3) - 1;
            3, 4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [3:0] op, input logic [31:0] a,
                                input logic [31:0] b, input bit has_exp, input t_rsp fixed);
        t_rsp e;
        while ($urandom_range(0, 99) < send_idle) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        e = alu_result(op, a, b);
        if (has_exp)
            e = fixed;
        i_req_valid <= 1'b1;
        i_req <= '{op, a, b};
        do
            @(posedge i_clk);
        while (!o_req_ready);
        expected_rsp.push_back(e);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("fixed_point_alu test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
            end
            if (o_rsp_valid && i_rsp_ready) begin
                if (expected_rsp.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected result %h", o_rsp);
                end else begin
                    if (o_rsp !== expected_rsp[0]) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected %h actual %h",
                                     expected_rsp[0], o_rsp);
                    end
                    void'(expected_rsp.pop_front());
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        int waited;
        rows.push_back(row(OP_ADD, MAX32, 32'd1, 1, MAX32, 0, 1, 0));
        rows.push_back(row(OP_ADD, MIN32, 32'hFFFF_FFFF, 1, MIN32, 0, 1, 0));
        rows.push_back(row(OP_SUB, MIN32, 32'd1, 1, MIN32, 0, 1, 0));
        rows.push_back(row(OP_SUB, 32'd0, MIN32, 1, MAX32, 0, 1, 0));
        rows.push_back(row(OP_MUL, 32'd384, 32'd384, 0, 0, 0, 0, 0));
        rows.push_back(row(OP_MUL, 32'hFFFF_FF80, 32'd1, 1, 32'hFFFF_FFFF, 0, 0, 0));
        rows.push_back(row(OP_MUL, MAX32, MAX32, 1, MAX32, 0, 1, 0));
        rows.push_back(row(OP_MUL, MIN32, MIN32, 1, MAX32, 0, 1, 0));
        rows.push_back(row(OP_DIV, 32'd256, 32'd0, 1, 0, 0, 0, 1));
        rows.push_back(row(OP_DIV, MIN32, 32'd0, 1, 0, 0, 0, 1));
        rows.push_back(row(OP_DIV, 32'd256, 32'd768, 0, 0, 0, 0, 0));
        rows.push_back(row(OP_DIV, MAX32, 32'd1, 1, MAX32, 0, 1, 0));
        rows.push_back(row(OP_DIV, MIN32, MIN32, 0, 0, 0, 0, 0));
        rows.push_back(row(OP_GT, MAX32, MIN32, 1, 0, 1, 0, 0));
        rows.push_back(row(OP_LT, MAX32, MIN32, 1, 0, 0, 0, 0));
        rows.push_back(row(OP_GE, 32'd5, 32'd5, 1, 0, 1, 0, 0));
        rows.push_back(row(OP_LE, MIN32, MIN32, 1, 0, 1, 0, 0));
        rows.push_back(row(OP_EQ, 32'd7, 32'd8, 1, 0, 0, 0, 0));
        rows.push_back(row(OP_NE, 32'd7, 32'd8, 1, 0, 1, 0, 0));
        rows.push_back(row(OP_MIN, MAX32, MIN32, 1, MIN32, 0, 0, 0));
        rows.push_back(row(OP_MAX, 32'd9, 32'd9, 1, 32'd9, 0, 0, 0));
        rows.push_back(row(OP_INC, MAX32, 32'hFFFF_FFFF, 1, MAX32, 0, 1, 0));
        rows.push_back(row(OP_DEC, MIN32, 32'hFFFF_FFFF, 1, MIN32, 0, 1, 0));
        rows.push_back(row(OP_TOINT, 32'hFFFF_FFFF, 32'd0, 1, 32'hFFFF_FFFF, 0, 0, 0));
        rows.push_back(row(4'd15, MAX32, MAX32, 1, 0, 0, 0, 0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_request(rows[i].op, rows[i].a, rows[i].b, rows[i].has_exp, rows[i].exp);

        for (int n = 0; n < 1700; n++) begin
            if (n == 560) begin
                send_idle = 64;
                recv_idle = 8;
            end
            if (n == 1120) begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (n == 300)
                hold_cycles = 150;
            if (n == 800) begin
                i_req_valid <= 1'b0;
                do
                    @(posedge i_clk);
                while (expected_rsp.size() != 0);
            end
            send_request(4'($urandom_range(0, 15)), rand_operand(), rand_operand(), 0, '0);
        end
        i_req_valid <= 1'b0;

        while (expected_rsp.size() != 0)
            @(posedge i_clk);
        waited = 0;
        while (waited < TAIL) begin
            @(posedge i_clk);
            waited++;
        end
        if (mismatches == 0) begin
            $display("fixed_point_alu test passed");
        end else begin
            $display("fixed_point_alu test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
